>>> rtl/http_byte_range_parser_macros.svh
// Assertion macros shared by the RTL of the byte range parser.
`ifndef HTTP_BYTE_RANGE_PARSER_MACROS_SVH
`define HTTP_BYTE_RANGE_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define HBR_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbr assertion failed");

// Next-cycle implication, checked outside reset
`define HBR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbr assertion failed");

`else

`define HBR_ASSERT_IMPLIES(name, clk, rst, ante, cons)

`define HBR_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> rtl/hbr_pkg.sv
package hbr_pkg;

  // Width of the number accumulators and of the result fields
  localparam int VALUE_BITS = 64;
  localparam int OUT_BITS   = 64;
  // Accumulator widened to hold value * 10 + 9 without wrap
  localparam int ACC_EXT_BITS = VALUE_BITS + 4;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  // Final status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Token characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CASE  = 8'h20;

  localparam logic [2:0] UNIT_LEN = 3'd5;

  // Lower-case letters of the unit name "bytes"
  function automatic logic [7:0] unit_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/hbr_in_if.sv
interface hbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

>>> rtl/hbr_out_if.sv
interface hbr_out_if;
  logic        valid;
  logic        ready;
  logic        range_valid;
  logic [63:0] range_start;
  logic [63:0] range_end;
  logic        final_res;
  logic [1:0]  status;

  modport source (
    output valid, output range_valid, output range_start, output range_end,
    output final_res, output status, input ready
  );
  modport sink (
    input valid, input range_valid, input range_start, input range_end,
    input final_res, input status, output ready
  );
endinterface

>>> rtl/http_byte_range_parser.sv
// Channel  | Dir | Payload                                            | Item
// ---------+-----+----------------------------------------------------+---------------------
// in_ch    | in  | char_code[7:0], last_char                          | one header byte
// out_ch   | out | range_valid, range_start[63:0], range_end[63:0],   | range done or last
//          |     | final_res, status[1:0]                             |
//
// One byte per cycle while out_ch is not stalled; a byte passes the byte stage, then the result register.
// The rate is set by the combinational digit step (acc * 10 + d, overflow test)
// between the input register and the result register.
// rst (synchronous) clears the byte stage, the result register and parse state.
// A stalled out_ch holds the result; in_ch keeps ready while the byte stage can
// drain into the result register in the same cycle.
`include "http_byte_range_parser_macros.svh"

module http_byte_range_parser (
  input  logic      clk,
  input  logic      rst,
  hbr_in_if.sink    in_ch,
  hbr_out_if.source out_ch
);
  import hbr_pkg::*;

  typedef enum logic [3:0] {
    PH_LEAD, PH_UNIT, PH_PRE_EQ, PH_SET_WS, PH_START,
    PH_START_TRAIL, PH_END, PH_TAIL, PH_ERR
  } phase_t;

  // Byte stage
  logic       s_vld;
  logic [7:0] s_char;
  logic       s_last;

  // Parse state
  phase_t                phase, phase_next;
  logic [2:0]            upos, upos_next;
  logic [VALUE_BITS-1:0] sacc, sacc_next;
  logic [VALUE_BITS-1:0] eacc, eacc_next;
  logic                  eseen, eseen_next;
  logic [1:0]            err, err_next;

  // Result register
  logic                o_vld;
  logic                o_range_valid;
  logic [OUT_BITS-1:0] o_start;
  logic [OUT_BITS-1:0] o_end;
  logic                o_final;
  logic [1:0]          o_status;

  // Step outputs
  logic                  got;
  logic [VALUE_BITS-1:0] got_start, got_end;
  logic [1:0]            status_now;
  logic                  produce;
  logic                  adv;

  // Character classes and digit step
  logic                    is_sp, is_dg;
  logic [3:0]              digit;
  logic [VALUE_BITS-1:0]   acc_sel;
  logic [ACC_EXT_BITS-1:0] acc_ext, acc_wide;
  logic [VALUE_BITS-1:0]   acc_new;
  logic                    acc_ovf;
  logic                    emit_req, emit_now, emit_ok;
  logic [VALUE_BITS-1:0]   end_val;

  assign is_sp = (s_char == CH_SPACE) || (s_char == CH_TAB);
  assign is_dg = s_char inside {[CH_ZERO:CH_NINE]};
  assign digit = s_char[3:0];

  // Pick the accumulator that this byte extends
  always_comb begin
    case (phase)
      PH_END:    acc_sel = eacc;
      PH_SET_WS: acc_sel = '0;
      default:   acc_sel = sacc;
    endcase
  end

  // acc * 10 + digit, exact overflow from the top bits
  assign acc_ext  = ACC_EXT_BITS'(acc_sel);
  assign acc_wide = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT_BITS'(digit);
  assign acc_new  = acc_wide[VALUE_BITS-1:0];
  assign acc_ovf  = |acc_wide[ACC_EXT_BITS-1:VALUE_BITS];

  // Advance the byte stage when the result register can take its item
  assign adv          = s_vld && (!o_vld || out_ch.ready);
  assign in_ch.ready  = !s_vld || adv;

  // Next parse state for the byte in the stage
  always_comb begin
    phase_next = phase;
    upos_next  = upos;
    sacc_next  = sacc;
    eacc_next  = eacc;
    eseen_next = eseen;
    err_next   = err;
    emit_req   = 1'b0;
    got        = 1'b0;
    got_start  = '0;
    got_end    = '0;
    status_now = ST_OK;
    emit_now   = 1'b0;
    emit_ok    = 1'b0;
    end_val    = '0;

    case (phase)
      PH_LEAD, PH_UNIT: begin
        if (!(phase == PH_LEAD && is_sp)) begin
          if (upos < UNIT_LEN && (s_char | CH_CASE) == unit_char(upos)) begin
            upos_next  = upos + 3'd1;
            phase_next = (upos_next == UNIT_LEN) ? PH_PRE_EQ : PH_UNIT;
          end else begin
            if (err_next == ST_OK) err_next = ST_INVALID;
            phase_next = PH_ERR;
          end
        end
      end
      PH_PRE_EQ: begin
        if (!is_sp) begin
          if (s_char == CH_EQ) begin
            phase_next = PH_SET_WS;
          end else begin
            if (err_next == ST_OK) err_next = ST_INVALID;
            phase_next = PH_ERR;
          end
        end
      end
      PH_SET_WS: begin
        if (!is_sp) begin
          sacc_next  = '0;
          eacc_next  = '0;
          eseen_next = 1'b0;
          if (is_dg) begin
            if (acc_ovf) begin
              if (err_next == ST_OK) err_next = ST_OVERFLOW;
              phase_next = PH_ERR;
            end else begin
              sacc_next  = acc_new;
              phase_next = PH_START;
            end
          end else if (s_char == CH_DASH) begin
            phase_next = PH_END;
          end else begin
            if (err_next == ST_OK) err_next = ST_INVALID;
            phase_next = PH_ERR;
          end
        end
      end
      PH_START, PH_START_TRAIL: begin
        if (phase == PH_START && is_dg) begin
          if (acc_ovf) begin
            if (err_next == ST_OK) err_next = ST_OVERFLOW;
            phase_next = PH_ERR;
          end else begin
            sacc_next = acc_new;
          end
        end else if (is_sp) begin
          phase_next = PH_START_TRAIL;
        end else if (s_char == CH_DASH) begin
          phase_next = PH_END;
        end else begin
          if (err_next == ST_OK) err_next = ST_INVALID;
          phase_next = PH_ERR;
        end
      end
      PH_END: begin
        if (is_dg) begin
          eseen_next = 1'b1;
          if (acc_ovf) begin
            if (err_next == ST_OK) err_next = ST_OVERFLOW;
            phase_next = PH_ERR;
          end else begin
            eacc_next = acc_new;
          end
        end else if (is_sp) begin
          if (eseen) begin
            emit_req   = 1'b1;
            phase_next = PH_TAIL;
          end
        end else if (s_char == CH_COMMA) begin
          emit_req   = 1'b1;
          phase_next = PH_SET_WS;
        end else begin
          if (err_next == ST_OK) err_next = ST_INVALID;
          phase_next = PH_ERR;
        end
      end
      PH_TAIL: begin
        if (!is_sp) begin
          if (s_char == CH_COMMA) begin
            phase_next = PH_SET_WS;
          end else begin
            if (err_next == ST_OK) err_next = ST_INVALID;
            phase_next = PH_ERR;
          end
        end
      end
      default: phase_next = PH_ERR;
    endcase

    // Close a set: after a separator, or at the last byte inside an end number
    emit_now = emit_req || (s_last && phase_next == PH_END);
    end_val  = eseen_next ? eacc_next : VALUE_MAX;
    emit_ok  = sacc_next <= end_val;
    if (emit_now) begin
      if (emit_ok) begin
        got        = 1'b1;
        got_start  = sacc_next;
        got_end    = end_val;
        sacc_next  = '0;
        eacc_next  = '0;
        eseen_next = 1'b0;
      end else begin
        if (err_next == ST_OK) err_next = ST_INVALID;
        phase_next = PH_ERR;
      end
    end

    // Finish the run on the last byte and return to the idle state
    if (s_last) begin
      if (!(phase_next == PH_SET_WS || phase_next == PH_TAIL ||
            phase_next == PH_ERR || phase_next == PH_END)) begin
        if (err_next == ST_OK) err_next = ST_INVALID;
      end
      status_now = err_next;
      phase_next = PH_LEAD;
      upos_next  = '0;
      sacc_next  = '0;
      eacc_next  = '0;
      eseen_next = 1'b0;
      err_next   = ST_OK;
    end
  end

  assign produce = got || s_last;

  // Byte stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s_vld <= 1'b1;
    end else if (adv) begin
      s_vld <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      s_char <= in_ch.char_code;
      s_last <= in_ch.last_char;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      upos  <= '0;
      sacc  <= '0;
      eacc  <= '0;
      eseen <= 1'b0;
      err   <= ST_OK;
    end else if (adv) begin
      phase <= phase_next;
      upos  <= upos_next;
      sacc  <= sacc_next;
      eacc  <= eacc_next;
      eseen <= eseen_next;
      err   <= err_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= produce;
    end else if (out_ch.ready) begin
      o_vld <= 1'b0;
    end
    if (adv) begin
      o_range_valid <= got;
      o_start       <= OUT_BITS'(got_start);
      o_end         <= OUT_BITS'(got_end);
      o_final       <= s_last;
      o_status      <= status_now;
    end
  end

  assign out_ch.valid       = o_vld;
  assign out_ch.range_valid = o_range_valid;
  assign out_ch.range_start = o_start;
  assign out_ch.range_end   = o_end;
  assign out_ch.final_res   = o_final;
  assign out_ch.status      = o_status;

  `HBR_ASSERT_IMPLIES(a_status_only_final, clk, rst, o_vld && !o_final, o_status == ST_OK)
  `HBR_ASSERT_IMPLIES(a_range_ordered, clk, rst, o_vld && o_range_valid, o_start <= o_end)
  `HBR_ASSERT_IMPLIES(a_no_range_zero, clk, rst, o_vld && !o_range_valid, o_start == '0 && o_end == '0)
  `HBR_ASSERT_NEXT(a_last_resets, clk, rst, adv && s_last, phase == PH_LEAD && err == ST_OK && upos == '0)
  `HBR_ASSERT_IMPLIES(a_err_has_code, clk, rst, phase == PH_ERR, err != ST_OK)

endmodule
